### rtl/core/maes128_pkg.sv
// ----------------------------------------------------------------------------
// maes128_pkg
// shared widths, types and tables for the modified aes-128 cipher unit
// ----------------------------------------------------------------------------
package maes128_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned NumRk   = 11;
  localparam int unsigned RkIdxW  = 4;
  localparam int unsigned AddrW   = 4;

  typedef logic [HalfW-1:0]  half_t;
  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  localparam logic [AddrW-1:0] RegKeyHigh = 4'h0;
  localparam logic [AddrW-1:0] RegKeyLow  = 4'h8;

  localparam byte_t Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam byte_t InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

endpackage

### rtl/core/maes128_req_if.sv
// ----------------------------------------------------------------------------
// maes128_req_if
// request channel: operation and 128-bit block
// ----------------------------------------------------------------------------
interface maes128_req_if;
  logic                  valid;
  logic                  ready;
  logic                  op;
  maes128_pkg::half_t    block_high;
  maes128_pkg::half_t    block_low;

  modport source (output valid, op, block_high, block_low, input ready);
  modport sink   (input valid, op, block_high, block_low, output ready);
endinterface

### rtl/core/maes128_rsp_if.sv
// ----------------------------------------------------------------------------
// maes128_rsp_if
// response channel: 128-bit result
// ----------------------------------------------------------------------------
interface maes128_rsp_if;
  logic                  valid;
  logic                  ready;
  maes128_pkg::half_t    result_high;
  maes128_pkg::half_t    result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

### rtl/core/modified_aes128_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// modified_aes128_block_cipher_unit
// iterative modified aes-128 encrypt/decrypt engine with apb key registers
// ----------------------------------------------------------------------------
// A block is accepted while the unit is idle and then passes through a single
// round unit (16 s-box lookups, row shift, column mix, key add) that is
// reused for each of the ten rounds. The unit takes a new transaction
// whenever it is idle, also while the previous result still waits in the
// result register. A result that is still not taken when the next one is due
// holds the last round until the result register frees up. After reset and
// after every key register write the round keys are rebuilt (one load, ten
// schedule steps through a four-lookup word unit); no transaction is accepted
// meanwhile.
module modified_aes128_block_cipher_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  maes128_req_if.sink                         req_i,
  maes128_rsp_if.source                       rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [maes128_pkg::AddrW-1:0]       paddr,
  input  logic [maes128_pkg::HalfW-1:0]       pwdata,
  output logic [maes128_pkg::HalfW-1:0]       prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EXPAND,
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [maes128_pkg::RkIdxW-1:0] LastRound = 4'd9;
  localparam logic [maes128_pkg::RkIdxW-1:0] FinalKey  = 4'd10;

  function automatic maes128_pkg::byte_t xtime(input maes128_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic maes128_pkg::byte_t gmul(input maes128_pkg::byte_t a,
                                              input maes128_pkg::byte_t b);
    maes128_pkg::byte_t acc;
    maes128_pkg::byte_t x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    return acc;
  endfunction

  function automatic maes128_pkg::byte_t get_byte(input maes128_pkg::block_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic maes128_pkg::block_t sub_fwd(input maes128_pkg::block_t s);
    maes128_pkg::block_t t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = maes128_pkg::Sbox[xtime(get_byte(s, i)) ^ 8'h01];
    end
    return t;
  endfunction

  function automatic maes128_pkg::block_t sub_inv(input maes128_pkg::block_t s);
    maes128_pkg::block_t t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = gmul(maes128_pkg::InvSbox[get_byte(s, i)] ^ 8'h01, 8'h8d);
    end
    return t;
  endfunction

  function automatic maes128_pkg::block_t shift_rows(input maes128_pkg::block_t s,
                                                     input logic inv);
    maes128_pkg::block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(4*r+c) -: 8] = inv ? get_byte(s, 4*r + ((c + 4 - r) & 3))
                                    : get_byte(s, 4*r + ((c + r) & 3));
      end
    end
    return t;
  endfunction

  function automatic maes128_pkg::block_t mix_columns(input maes128_pkg::block_t s,
                                                      input logic inv);
    maes128_pkg::block_t t;
    maes128_pkg::byte_t  k [4];
    maes128_pkg::byte_t  v;
    if (inv) begin
      k = '{8'ha5, 8'h07, 8'h1a, 8'h73};
    end else begin
      k = '{8'h01, 8'h04, 8'h04, 8'h05};
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        v = 8'h00;
        for (int d = 0; d < 4; d++) begin
          v = v ^ gmul(get_byte(s, 4*((j + d) & 3) + c), k[d]);
        end
        t[127-8*(4*j+c) -: 8] = v;
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] rcon(input logic [maes128_pkg::RkIdxW-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      4'd0:    r = 32'h0100_0000;
      4'd1:    r = 32'h0200_0000;
      4'd2:    r = 32'h0400_0000;
      4'd3:    r = 32'h0800_0000;
      4'd4:    r = 32'h1000_0000;
      4'd5:    r = 32'h2000_0000;
      4'd6:    r = 32'h4000_0000;
      4'd7:    r = 32'h8000_0000;
      4'd8:    r = 32'h1b00_0000;
      4'd9:    r = 32'h3600_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  state_e                               state_q;
  logic [maes128_pkg::RkIdxW-1:0]       kidx_q;
  logic [maes128_pkg::RkIdxW-1:0]       rnd_q;
  logic                                 op_q;
  maes128_pkg::block_t                  s_q;
  maes128_pkg::block_t                  res_q;
  logic                                 res_valid_q;
  maes128_pkg::half_t                   key_hi_q;
  maes128_pkg::half_t                   key_lo_q;
  maes128_pkg::block_t                  rk_q [maes128_pkg::NumRk];

  logic                                 cfg_wr;
  logic                                 in_acc;
  logic                                 res_free;
  logic                                 run_end;
  logic [maes128_pkg::RkIdxW-1:0]       rd_idx;
  maes128_pkg::block_t                  rk_rd;
  maes128_pkg::block_t                  rk_last;
  logic [31:0]                          w0, w1, w2, w3, tw, n0, n1, n2, n3;
  maes128_pkg::block_t                  enc_a, enc_b, enc_nx;
  maes128_pkg::block_t                  dec_a, dec_b, dec_nx;
  maes128_pkg::block_t                  rnd_nx;
  logic                                 rnd_done;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? key_lo_q : key_hi_q;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign in_acc            = req_i.valid & req_i.ready;
  assign rsp_o.valid       = res_valid_q;
  assign rsp_o.result_high = res_q[127:64];
  assign rsp_o.result_low  = res_q[63:0];

  // result register can take a new block
  assign res_free = ~res_valid_q | rsp_o.ready;
  assign run_end  = (state_q == ST_RUN) & rnd_done & res_free;

  // one read port, shared by schedule and rounds
  assign rd_idx  = (state_q == ST_EXPAND) ? kidx_q - 4'd1 : rnd_q;
  assign rk_rd   = rk_q[rd_idx];
  assign rk_last = rk_q[FinalKey];

  // schedule step
  always_comb begin
    w0 = rk_rd[127:96];
    w1 = rk_rd[95:64];
    w2 = rk_rd[63:32];
    w3 = rk_rd[31:0];
    tw = {maes128_pkg::Sbox[w3[23:16]], maes128_pkg::Sbox[w3[15:8]],
          maes128_pkg::Sbox[w3[7:0]],   maes128_pkg::Sbox[w3[31:24]]}
         ^ rcon(kidx_q - 4'd1);
    n0 = w0 ^ tw;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
  end

  // round unit
  always_comb begin
    enc_a  = shift_rows(sub_fwd(s_q ^ rk_rd), 1'b0);
    enc_nx = (rnd_q == LastRound) ? (enc_a ^ rk_last) : mix_columns(enc_a, 1'b0);
    dec_a  = (rnd_q == LastRound) ? (s_q ^ rk_last) : s_q;
    dec_b  = (rnd_q == LastRound) ? dec_a : mix_columns(dec_a, 1'b1);
    enc_b  = sub_inv(shift_rows(dec_b, 1'b1));
    dec_nx = enc_b ^ rk_rd;
    rnd_nx = (op_q == maes128_pkg::OP_DECRYPT) ? dec_nx : enc_nx;
    rnd_done = (op_q == maes128_pkg::OP_DECRYPT) ? (rnd_q == 4'd0) : (rnd_q == LastRound);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      kidx_q      <= 4'd1;
      rnd_q       <= 4'd0;
      op_q        <= 1'b0;
      res_valid_q <= 1'b0;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
    end else begin
      if (run_end) res_valid_q <= 1'b1;
      else if (rsp_o.valid && rsp_o.ready) res_valid_q <= 1'b0;
      if (cfg_wr) begin
        if (paddr[3]) key_lo_q <= pwdata;
        else          key_hi_q <= pwdata;
        state_q <= ST_LOAD;
      end else begin
        unique case (state_q)
          ST_LOAD: begin
            kidx_q  <= 4'd1;
            state_q <= ST_EXPAND;
          end
          ST_EXPAND: begin
            kidx_q <= kidx_q + 4'd1;
            if (kidx_q == FinalKey) state_q <= ST_IDLE;
          end
          ST_IDLE: begin
            if (in_acc) begin
              op_q    <= req_i.op;
              rnd_q   <= (req_i.op == maes128_pkg::OP_DECRYPT) ? LastRound : 4'd0;
              state_q <= ST_RUN;
            end
          end
          ST_RUN: begin
            if (rnd_done) begin
              if (res_free) state_q <= ST_IDLE;
            end else if (op_q == maes128_pkg::OP_DECRYPT) begin
              rnd_q <= rnd_q - 4'd1;
            end else begin
              rnd_q <= rnd_q + 4'd1;
            end
          end
          default: state_q <= ST_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s_q <= {req_i.block_high, req_i.block_low};
    else if (state_q == ST_RUN && (!rnd_done || res_free)) s_q <= rnd_nx;
    if (run_end) res_q <= rnd_nx;
    if (state_q == ST_LOAD) rk_q[0] <= {key_hi_q, key_lo_q};
    if (state_q == ST_EXPAND) rk_q[kidx_q] <= {n0, n1, n2, n3};
  end

`ifndef NO_ASSERTIONS
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_IDLE))
    else $error("transaction accepted while busy");
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rnd_q <= LastRound))
    else $error("round counter out of range");
  a_kidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPAND) |-> (kidx_q >= 4'd1) && (kidx_q <= FinalKey))
    else $error("schedule index out of range");
  a_res_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == ST_RUN)
    else $error("result raised outside a round run");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !rsp_o.ready) |=> res_valid_q && $stable(res_q))
    else $error("waiting result changed");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the modified aes-128 unit: blocks from a queue are encrypted or
// decrypted under several keys and each result is compared with a local model
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    maes128_pkg::op_e   op;
    maes128_pkg::half_t hi;
    maes128_pkg::half_t lo;
  } blk_req_t;

  typedef struct {
    maes128_pkg::half_t hi;
    maes128_pkg::half_t lo;
  } blk_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [maes128_pkg::AddrW-1:0] paddr = '0;
  maes128_pkg::half_t pwdata = '0;
  maes128_pkg::half_t prdata;
  logic pready;

  maes128_req_if req_if ();
  maes128_rsp_if rsp_if ();

  modified_aes128_block_cipher_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  blk_req_t pending_blocks[$];
  blk_res_t expected_results[$];
  logic [31:0] rk_words [44];
  maes128_pkg::half_t key_hi_m, key_lo_m;
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_send = 1'b0;
  bit req_done = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic maes128_pkg::byte_t xt(maes128_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic maes128_pkg::byte_t gf_mul(maes128_pkg::byte_t a, maes128_pkg::byte_t b);
    maes128_pkg::byte_t acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xt(a);
    end
    return acc;
  endfunction

  function automatic void build_schedule();
    logic [31:0] t;
    logic [31:0] rc;
    rk_words[0] = key_hi_m[63:32];
    rk_words[1] = key_hi_m[31:0];
    rk_words[2] = key_lo_m[63:32];
    rk_words[3] = key_lo_m[31:0];
    rc = 32'h01000000;
    for (int i = 4; i < 44; i++) begin
      t = rk_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {maes128_pkg::Sbox[t[31:24]], maes128_pkg::Sbox[t[23:16]],
             maes128_pkg::Sbox[t[15:8]], maes128_pkg::Sbox[t[7:0]]} ^ rc;
        rc = {xt(rc[31:24]), 24'h0};
      end
      rk_words[i] = rk_words[i-4] ^ t;
    end
  endfunction

  function automatic blk_res_t cipher_block(blk_req_t r);
    maes128_pkg::byte_t s[16], t[16];
    maes128_pkg::byte_t fm[4], im[4];
    blk_res_t res;
    fm = '{8'h01, 8'h04, 8'h04, 8'h05};
    im = '{8'ha5, 8'h07, 8'h1a, 8'h73};
    for (int i = 0; i < 8; i++) begin
      s[i] = r.hi[63-8*i -: 8];
      s[8+i] = r.lo[63-8*i -: 8];
    end
    for (int step = 0; step < 11; step++) begin
      int rnd;
      rnd = (r.op == maes128_pkg::OP_ENCRYPT) ? step : 10 - step;
      if (r.op == maes128_pkg::OP_DECRYPT && step > 0) begin
        if (rnd < 9) begin
          for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) begin
              t[4*j+c] = 0;
              for (int d = 0; d < 4; d++) t[4*j+c] ^= gf_mul(s[4*((j+d)%4)+c], im[d]);
            end
          s = t;
        end
        for (int rr = 0; rr < 4; rr++)
          for (int c = 0; c < 4; c++) t[4*rr+c] = s[4*rr+((c+4-rr)%4)];
        for (int i = 0; i < 16; i++)
          t[i] = gf_mul(maes128_pkg::InvSbox[t[i]] ^ 8'h01, 8'h8d);
        s = t;
      end
      for (int m = 0; m < 4; m++)
        for (int n = 0; n < 4; n++) s[4*m+n] ^= rk_words[4*rnd+m][31-8*n -: 8];
      if (r.op == maes128_pkg::OP_ENCRYPT && step < 10) begin
        for (int rr = 0; rr < 4; rr++)
          for (int c = 0; c < 4; c++)
            t[4*rr+c] = maes128_pkg::Sbox[xt(s[4*rr+((c+rr)%4)]) ^ 8'h01];
        s = t;
        if (step < 9) begin
          for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) begin
              t[4*j+c] = 0;
              for (int d = 0; d < 4; d++) t[4*j+c] ^= gf_mul(s[4*((j+d)%4)+c], fm[d]);
            end
          s = t;
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, maes128_pkg::half_t got,
                                 maes128_pkg::half_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // driver
  initial begin
    req_if.valid = 1'b0;
    req_if.op = 1'b0;
    req_if.block_high = '0;
    req_if.block_low = '0;
    rsp_if.ready = 1'b0;
  end

  // input transaction accepted at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      void'(pending_blocks.pop_front());
      expected_results.push_back(cipher_block('{maes128_pkg::op_e'(req_if.op),
                                                req_if.block_high, req_if.block_low}));
      req_done = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_done) begin
        if (!hold_send && pending_blocks.size() > 0 &&
            (no_idle || $urandom_range(99) >= 19)) begin
          req_if.valid <= 1'b1;
          req_if.op <= pending_blocks[0].op;
          req_if.block_high <= pending_blocks[0].hi;
          req_if.block_low <= pending_blocks[0].lo;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      req_done = 1'b0;
      rsp_if.ready <= no_idle || $urandom_range(99) >= 19;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", rsp_if.result_high, rsp_if.result_low);
      end else begin
        if (rsp_if.result_high !== expected_results[0].hi)
          report_mismatch("result_high", rsp_if.result_high, expected_results[0].hi);
        if (rsp_if.result_low !== expected_results[0].lo)
          report_mismatch("result_low", rsp_if.result_low, expected_results[0].lo);
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || expected_results.size() > 0 || req_if.valid)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [maes128_pkg::AddrW-1:0] addr, maes128_pkg::half_t data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == maes128_pkg::RegKeyHigh) key_hi_m = data;
    else key_lo_m = data;
    build_schedule();
  endtask

  function automatic maes128_pkg::half_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic maes128_pkg::half_t edge64();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return maes128_pkg::half_t'(1) << $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  task automatic add_block(maes128_pkg::op_e op, maes128_pkg::half_t hi,
                           maes128_pkg::half_t lo);
    pending_blocks.push_back('{op, hi, lo});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_block(maes128_pkg::op_e'($urandom_range(1)),
                ($urandom_range(9) == 0) ? edge64() : rand64(),
                ($urandom_range(9) == 0) ? edge64() : rand64());
  endtask

  initial begin
    maes128_pkg::half_t kh[5], kl[5];
    blk_res_t ct;
    kh = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0001_0203_0405_0607, 64'h0};
    kl = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h1, 64'h0809_0a0b_0c0d_0e0f, 64'h0};
    key_hi_m = '0;
    key_lo_m = '0;
    build_schedule();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero key straight out of reset
    add_block(maes128_pkg::OP_ENCRYPT, '0, '0);
    add_block(maes128_pkg::OP_DECRYPT, '0, '0);
    add_block(maes128_pkg::OP_ENCRYPT, '1, '1);
    add_block(maes128_pkg::OP_DECRYPT, '1, '1);
    add_block(maes128_pkg::OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    add_block(maes128_pkg::OP_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drained();

    for (int k = 0; k < 5; k++) begin
      maes128_pkg::half_t h, l;
      h = (k == 4) ? rand64() : kh[k];
      l = (k == 4) ? rand64() : kl[k];
      apb_write(maes128_pkg::RegKeyHigh, h);
      apb_write(maes128_pkg::RegKeyLow, l);
      if (k == 1) begin
        // round trip and extremes under the all-ones key
        ct = cipher_block('{maes128_pkg::OP_ENCRYPT, 64'h0011_2233_4455_6677,
                            64'h8899_aabb_ccdd_eeff});
        add_block(maes128_pkg::OP_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        add_block(maes128_pkg::OP_DECRYPT, ct.hi, ct.lo);
        add_block(maes128_pkg::OP_ENCRYPT, '0, '1);
        add_block(maes128_pkg::OP_DECRYPT, '1, '0);
      end
      if (k == 2) begin
        no_idle = 1'b1;
        add_random(150);
        wait_drained();
        no_idle = 1'b0;
      end
      add_random(k == 0 ? 200 : 190);
      if (k == 3) begin
        while (pending_blocks.size() > 120) @(negedge clk_i);
        hold_send = 1'b1;
        while (expected_results.size() > 0 || req_if.valid) @(negedge clk_i);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(20ns * 300000);
    $display("tb: FAIL");
    $finish;
  end
endmodule

### modified_aes128_block_cipher_unit.f
rtl/core/maes128_pkg.sv
rtl/core/maes128_req_if.sv
rtl/core/maes128_rsp_if.sv
rtl/core/modified_aes128_block_cipher_unit.sv
tb/sv/tb.sv
